// File: rtl/impact_freefall_detector_unit_defines.svh
// Assertion helpers for the detector modules; only the merge module includes them.
`ifndef IMPACT_FREEFALL_DETECTOR_UNIT_DEFINES_SVH
`define IMPACT_FREEFALL_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define IFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ifd check failed: label");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define IFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ifd check failed: label");

`endif

// File: rtl/ifd_pkg.sv
package ifd_pkg;

    localparam int IFD_SAMPLE_BITS = 16;
    localparam int IFD_TIME_BITS   = 32;

    localparam int IFD_LEVEL_BITS  = 16;
    localparam int IFD_LEVEL_SQ_BITS = 2 * IFD_LEVEL_BITS;
    localparam int IFD_HOLD_BITS   = 16;
    localparam int IFD_ADDR_BITS   = 4;
    localparam int IFD_DATA_BITS   = 32;

    localparam logic [IFD_LEVEL_BITS-1:0] IFD_IMPACT_RESET   = 16'd40960;
    localparam logic [IFD_LEVEL_BITS-1:0] IFD_FREEFALL_RESET = 16'd8192;
    localparam logic [IFD_HOLD_BITS-1:0]  IFD_HOLD_RESET     = 16'd100;

    typedef enum logic [1:0] {
        REG_IMPACT   = 2'd0,
        REG_FREEFALL = 2'd1,
        REG_HOLD     = 2'd2
    } t_reg_idx;

    // Thresholds as the merge stage consumes them: levels already squared.
    typedef struct packed {
        logic [IFD_LEVEL_SQ_BITS-1:0] impact_sq;
        logic [IFD_LEVEL_SQ_BITS-1:0] freefall_sq;
        logic [IFD_HOLD_BITS-1:0]     hold_ms;
    } t_ifd_cfg;

endpackage

// File: rtl/ifd_lane.sv
module ifd_lane
    import ifd_pkg::*;
#(
    parameter int SAMPLE_BITS = IFD_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic [2*SAMPLE_BITS-1:0]      o_square
);

    logic [SAMPLE_BITS-1:0]   w_abs;
    logic [2*SAMPLE_BITS-1:0] r_square;

    // Magnitude of the most negative code still fits as unsigned.
    assign w_abs = i_sample[SAMPLE_BITS-1] ? (~i_sample + SAMPLE_BITS'(1)) : i_sample;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_square <= (2*SAMPLE_BITS)'(w_abs) * (2*SAMPLE_BITS)'(w_abs);
        end
    end

    assign o_square = r_square;

endmodule

// File: rtl/ifd_merge.sv
`include "impact_freefall_detector_unit_defines.svh"

module ifd_merge
    import ifd_pkg::*;
#(
    parameter int SAMPLE_BITS = IFD_SAMPLE_BITS,
    parameter int TIME_BITS   = IFD_TIME_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ifd_cfg                 i_cfg,
    input  logic                     i_valid,
    input  logic [2*SAMPLE_BITS-1:0] i_sq_x,
    input  logic [2*SAMPLE_BITS-1:0] i_sq_y,
    input  logic [2*SAMPLE_BITS-1:0] i_sq_z,
    input  logic [TIME_BITS-1:0]     i_now,
    output logic                     o_adv,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_stop_event,
    output logic                     o_impact_armed,
    output logic                     o_fall_timing
);

    localparam int SUM_BITS = 2 * SAMPLE_BITS + 2;
    localparam int CMP_BITS = (SUM_BITS > IFD_LEVEL_SQ_BITS) ? SUM_BITS : IFD_LEVEL_SQ_BITS;

    logic [SUM_BITS-1:0]  w_mag2;
    logic [CMP_BITS-1:0]  w_mag_cmp;
    logic                 w_impact;
    logic                 w_freefall;
    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_held;

    logic                 r_armed, n_armed;
    logic                 r_timing, n_timing;
    logic [TIME_BITS-1:0] r_start, n_start;
    logic                 n_stop;
    logic                 r_valid;
    logic                 r_stop, r_out_armed, r_out_timing;

    assign w_mag2 = SUM_BITS'(i_sq_x) + SUM_BITS'(i_sq_y) + SUM_BITS'(i_sq_z);
    assign w_mag_cmp  = CMP_BITS'(w_mag2);
    assign w_impact   = w_mag_cmp >= CMP_BITS'(i_cfg.impact_sq);
    assign w_freefall = w_mag_cmp <= CMP_BITS'(i_cfg.freefall_sq);
    assign w_elapsed  = i_now - r_start;
    assign w_held     = w_elapsed >= TIME_BITS'(i_cfg.hold_ms);

    assign o_adv = i_valid && (!r_valid || !i_stall);

    always_comb begin
        n_armed  = r_armed;
        n_timing = r_timing;
        n_start  = r_start;
        n_stop   = 1'b0;
        if (!r_armed) begin
            if (w_impact) begin
                n_armed  = 1'b1;
                n_timing = 1'b0;
            end
        end else if (w_freefall) begin
            if (!r_timing) begin
                n_start  = i_now;
                n_timing = 1'b1;
            end else if (w_held) begin
                n_stop   = 1'b1;
                n_armed  = 1'b0;
                n_timing = 1'b0;
            end
        end else begin
            n_timing = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed  <= 1'b0;
            r_timing <= 1'b0;
            r_start  <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (o_adv) begin
                r_armed  <= n_armed;
                r_timing <= n_timing;
                r_start  <= n_start;
                r_valid  <= 1'b1;
            end else if (!i_stall) begin
                r_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_stop       <= n_stop;
            r_out_armed  <= n_armed;
            r_out_timing <= n_timing;
        end
    end

    assign o_valid        = r_valid;
    assign o_stop_event   = r_stop;
    assign o_impact_armed = r_out_armed;
    assign o_fall_timing  = r_out_timing;

    `IFD_ASSERT_NOW(a_timing_needs_arm, 1'b1, !r_timing || r_armed)
    `IFD_ASSERT_NOW(a_stop_disarms_out, r_valid && r_stop, !r_out_armed && !r_out_timing)
    `IFD_ASSERT_NEXT(a_stop_clears_state, o_adv && n_stop, !r_armed && !r_timing)
    `IFD_ASSERT_NEXT(a_stop_needs_arm, o_adv && !r_armed, !(r_valid && r_stop))

endmodule

// File: rtl/impact_freefall_detector_unit.sv
// Path: a sample passes the lane registers, then the merge result register, before its result transfers.
// Throughput: one sample per cycle while the input does not stall; a new sample is taken while a result waits.
// The input stalls only when the lane stage is full and the result is held.
// Reset (synchronous, active low): disarmed, not timing, pipeline empty,
// thresholds back to 2.5 g impact, 0.5 g free fall and a 100 ms hold.
module impact_freefall_detector_unit
    import ifd_pkg::*;
#(
    parameter int SAMPLE_BITS = IFD_SAMPLE_BITS,
    parameter int TIME_BITS   = IFD_TIME_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_z,
    input  logic [TIME_BITS-1:0]          i_now_ms,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_stop_event,
    output logic                          o_impact_armed,
    output logic                          o_fall_timing,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [IFD_ADDR_BITS-1:0]      paddr,
    input  logic [IFD_DATA_BITS-1:0]      pwdata,
    output logic [IFD_DATA_BITS-1:0]      prdata,
    output logic                          pready
);

    // ---------------------------------------------------------------
    // Register file. Each level is kept raw for readback and squared,
    // so the merge stage compares squared magnitudes with no root.
    // ---------------------------------------------------------------
    logic [IFD_LEVEL_BITS-1:0]    r_impact_level;
    logic [IFD_LEVEL_BITS-1:0]    r_freefall_level;
    logic [IFD_HOLD_BITS-1:0]     r_hold_ms;
    t_ifd_cfg                     r_cfg;
    logic                         w_wr;
    t_reg_idx                     w_idx;
    logic [IFD_LEVEL_BITS-1:0]    w_wval;
    logic [IFD_LEVEL_SQ_BITS-1:0] w_wval_wide;

    assign pready      = 1'b1;
    assign w_wr        = psel && penable && pwrite && pready;
    assign w_idx       = t_reg_idx'(paddr[3:2]);
    assign w_wval      = pwdata[IFD_LEVEL_BITS-1:0];
    assign w_wval_wide = IFD_LEVEL_SQ_BITS'(w_wval);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_impact_level    <= IFD_IMPACT_RESET;
            r_freefall_level  <= IFD_FREEFALL_RESET;
            r_hold_ms         <= IFD_HOLD_RESET;
            r_cfg.impact_sq   <= IFD_LEVEL_SQ_BITS'(IFD_IMPACT_RESET)
                                 * IFD_LEVEL_SQ_BITS'(IFD_IMPACT_RESET);
            r_cfg.freefall_sq <= IFD_LEVEL_SQ_BITS'(IFD_FREEFALL_RESET)
                                 * IFD_LEVEL_SQ_BITS'(IFD_FREEFALL_RESET);
            r_cfg.hold_ms     <= IFD_HOLD_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_IMPACT: begin
                    r_impact_level  <= w_wval;
                    r_cfg.impact_sq <= w_wval_wide * w_wval_wide;
                end
                REG_FREEFALL: begin
                    r_freefall_level  <= w_wval;
                    r_cfg.freefall_sq <= w_wval_wide * w_wval_wide;
                end
                REG_HOLD: begin
                    r_hold_ms     <= w_wval;
                    r_cfg.hold_ms <= w_wval;
                end
                default: ; // drop writes outside the register map
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_IMPACT:   prdata = IFD_DATA_BITS'(r_impact_level);
            REG_FREEFALL: prdata = IFD_DATA_BITS'(r_freefall_level);
            REG_HOLD:     prdata = IFD_DATA_BITS'(r_hold_ms);
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Lane stage: one squarer per axis, all loaded by the same transfer.
    // The timestamp rides alongside. The stage refills whenever the
    // merge stage drains it, so it never blocks while a slot is free.
    // ---------------------------------------------------------------
    logic                     r_s1_valid;
    logic [TIME_BITS-1:0]     r_s1_now;
    logic                     w_load;
    logic                     w_adv;
    logic [2*SAMPLE_BITS-1:0] w_sq_x, w_sq_y, w_sq_z;

    assign o_in_stall = r_s1_valid && !w_adv;
    assign w_load     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_load) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_s1_now <= i_now_ms;
        end
    end

    ifd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
        .i_clk    (i_clk),
        .i_en     (w_load),
        .i_sample (i_accel_x),
        .o_square (w_sq_x)
    );

    ifd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
        .i_clk    (i_clk),
        .i_en     (w_load),
        .i_sample (i_accel_y),
        .o_square (w_sq_y)
    );

    ifd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
        .i_clk    (i_clk),
        .i_en     (w_load),
        .i_sample (i_accel_z),
        .o_square (w_sq_z)
    );

    // ---------------------------------------------------------------
    // Merge stage: sum of squares, threshold compares, detector state
    // and the result register. Hold the result while the sink stalls.
    // ---------------------------------------------------------------
    ifd_merge #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (r_s1_valid),
        .i_sq_x         (w_sq_x),
        .i_sq_y         (w_sq_y),
        .i_sq_z         (w_sq_z),
        .i_now          (r_s1_now),
        .o_adv          (w_adv),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_stop_event   (o_stop_event),
        .o_impact_armed (o_impact_armed),
        .o_fall_timing  (o_fall_timing)
    );

endmodule
